// ===== design/sjfq_pkg.sv =====
// Shared types and codes for the shortest-job-first request queue.
// Used by sjfq_cmp, the queue top and the bench; depends on nothing.
package sjfq_pkg;

  // Request kinds
  localparam logic [1:0] REQ_ENQ    = 2'd0;
  localparam logic [1:0] REQ_DEQ    = 2'd1;
  localparam logic [1:0] REQ_CANCEL = 2'd2;

  // Result status codes
  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_MISS = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] job_id;
    logic [15:0] pred_len;
    logic [15:0] len_limit;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_id;
    logic [15:0] granted_priority;
    logic [4:0]  queue_depth;
    logic [63:0] enqueued_total;
    logic [63:0] dequeued_total;
  } rsp_t;

  // One stored slot: id, priority and arrival stamp
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] prio;
    logic [31:0] arrival;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

// ===== design/sjfq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the slot payload of the queue; no package dependency.
module sjfq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sjfq_cmp.sv =====
// Shared ordering unit: decides whether a candidate slot orders ahead of the
// current best (lower priority, then greater age, then lower index). Uses sjfq_pkg.
module sjfq_cmp #(
  parameter int IDX_W = 4
) (
  input  logic [31:0]         arrival_now,
  input  sjfq_pkg::slot_t     cand,
  input  logic [IDX_W-1:0]    cand_idx,
  input  logic [15:0]         best_prio,
  input  logic [31:0]         best_age,
  input  logic [IDX_W-1:0]    best_idx,
  output logic [31:0]         cand_age,
  output logic                ahead
);

  // Age wraps modulo 2^32; greater age means earlier arrival
  assign cand_age = arrival_now - cand.arrival;

  always_comb begin
    if (cand.prio != best_prio) begin
      ahead = cand.prio < best_prio;
    end else if (cand_age != best_age) begin
      ahead = cand_age > best_age;
    end else begin
      ahead = cand_idx < best_idx;
    end
  end

endmodule

// ===== design/shortest_job_first_queue.sv =====
// Shortest-job-first request queue: sequencer, slot flags and counters.
// Depends on sjfq_pkg, sjfq_ram (slot payload) and sjfq_cmp (ordering unit).
//
//   channel | ports                        | payload
//   --------+------------------------------+------------------------
//   request | in_valid, in_stall, in_req   | sjfq_pkg::req_t
//   result  | out_valid, out_stall, out_rsp| sjfq_pkg::rsp_t
//
// One request at a time; in_stall is high from acceptance until the result
// is loaded into the output register. Slots are walked one per cycle: a cancel
// walks them once through the payload RAM read port, a dequeue twice (once if
// none is servable) via it and the shared ordering unit; an enqueue stops at a free slot.
// Reset (rst_n low, synchronous) empties the queue and clears all totals.
// A stalled result holds; the next request is still taken while it waits.
module shortest_job_first_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sjfq_pkg::req_t   in_req,
  output logic             out_valid,
  input  logic             out_stall,
  output sjfq_pkg::rsp_t   out_rsp
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IW-1:0] LAST = IW'(QUEUE_DEPTH - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ENQ    = 3'd1;
  localparam logic [2:0] S_SCAN1  = 3'd2;
  localparam logic [2:0] S_SCAN2  = 3'd3;
  localparam logic [2:0] S_CANCEL = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]             state_r, state_nxt;
  sjfq_pkg::req_t         req_r, req_nxt;
  logic [QUEUE_DEPTH-1:0] valid_r, valid_nxt;
  logic [QUEUE_DEPTH-1:0] canc_r, canc_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [31:0]            arr_ctr_r, arr_ctr_nxt;
  logic [63:0]            enq_r, enq_nxt;
  logic [63:0]            deq_r, deq_nxt;
  logic [IW-1:0]          scan_r, scan_nxt;
  logic                   issue_r, issue_nxt;
  logic                   pv_r, pv_nxt;
  logic [IW-1:0]          pidx_r, pidx_nxt;
  logic                   bfound_r, bfound_nxt;
  logic [IW-1:0]          bidx_r, bidx_nxt;
  logic [15:0]            bprio_r, bprio_nxt;
  logic [31:0]            bage_r, bage_nxt;
  logic [15:0]            bid_r, bid_nxt;
  logic                   found_r, found_nxt;
  logic [1:0]             sts_r, sts_nxt;
  logic [15:0]            gid_r, gid_nxt;
  logic [15:0]            gpri_r, gpri_nxt;
  sjfq_pkg::rsp_t         out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   ram_we;
  sjfq_pkg::slot_t        ram_wdata;
  sjfq_pkg::slot_t        rd;
  logic [31:0]            cand_age;
  logic                   ahead;
  logic                   take;
  logic                   last_proc;

  assign ram_wdata.id      = req_r.job_id;
  assign ram_wdata.prio    = (req_r.pred_len != 16'd0) ? req_r.pred_len
                                                       : req_r.len_limit;
  assign ram_wdata.arrival = arr_ctr_r;
  assign ram_we = (state_r == S_ENQ) && !valid_r[scan_r];

  sjfq_ram #(
    .WIDTH (sjfq_pkg::SLOT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (scan_r),
    .wdata (ram_wdata),
    .raddr (scan_r),
    .rdata (rd)
  );

  sjfq_cmp #(
    .IDX_W (IW)
  ) u_cmp (
    .arrival_now (arr_ctr_r),
    .cand        (rd),
    .cand_idx    (pidx_r),
    .best_prio   (bprio_r),
    .best_age    (bage_r),
    .best_idx    (bidx_r),
    .cand_age    (cand_age),
    .ahead       (ahead)
  );

  assign take      = pv_r && valid_r[pidx_r] && !canc_r[pidx_r] && (!bfound_r || ahead);
  assign last_proc = pv_r && !issue_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    valid_nxt     = valid_r;
    canc_nxt      = canc_r;
    cnt_nxt       = cnt_r;
    arr_ctr_nxt   = arr_ctr_r;
    enq_nxt       = enq_r;
    deq_nxt       = deq_r;
    scan_nxt      = scan_r;
    issue_nxt     = issue_r;
    pv_nxt        = pv_r;
    pidx_nxt      = pidx_r;
    bfound_nxt    = bfound_r;
    bidx_nxt      = bidx_r;
    bprio_nxt     = bprio_r;
    bage_nxt      = bage_r;
    bid_nxt       = bid_r;
    found_nxt     = found_r;
    sts_nxt       = sts_r;
    gid_nxt       = gid_r;
    gpri_nxt      = gpri_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Advance the slot walk: issue a read, process the slot read last cycle
    if (state_r == S_SCAN1 || state_r == S_SCAN2 || state_r == S_CANCEL) begin
      if (issue_r) begin
        pv_nxt    = 1'b1;
        pidx_nxt  = scan_r;
        scan_nxt  = scan_r + IW'(1);
        issue_nxt = (scan_r != LAST);
      end else begin
        pv_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req;
          gid_nxt   = 16'd0;
          gpri_nxt  = 16'd0;
          scan_nxt  = '0;
          issue_nxt = 1'b1;
          pv_nxt    = 1'b0;
          unique case (in_req.req_type)
            sjfq_pkg::REQ_ENQ: begin
              state_nxt = S_ENQ;
            end
            sjfq_pkg::REQ_DEQ: begin
              bfound_nxt = 1'b0;
              state_nxt  = S_SCAN1;
            end
            sjfq_pkg::REQ_CANCEL: begin
              found_nxt = 1'b0;
              state_nxt = S_CANCEL;
            end
            default: begin
              sts_nxt   = sjfq_pkg::STS_MISS;
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_ENQ: begin
        if (!valid_r[scan_r]) begin
          valid_nxt[scan_r] = 1'b1;
          canc_nxt[scan_r]  = 1'b0;
          cnt_nxt           = cnt_r + CW'(1);
          arr_ctr_nxt       = arr_ctr_r + 32'd1;
          enq_nxt           = enq_r + 64'd1;
          sts_nxt           = sjfq_pkg::STS_OK;
          state_nxt         = S_DONE;
        end else if (scan_r == LAST) begin
          sts_nxt   = sjfq_pkg::STS_FULL;
          state_nxt = S_DONE;
        end else begin
          scan_nxt = scan_r + IW'(1);
        end
      end

      S_SCAN1: begin
        if (take) begin
          bfound_nxt = 1'b1;
          bidx_nxt   = pidx_r;
          bprio_nxt  = rd.prio;
          bage_nxt   = cand_age;
          bid_nxt    = rd.id;
        end
        if (last_proc) begin
          if (!(bfound_r || take)) begin
            // Nothing servable: drop every cancelled entry
            valid_nxt = '0;
            canc_nxt  = '0;
            cnt_nxt   = '0;
            sts_nxt   = sjfq_pkg::STS_MISS;
            state_nxt = S_DONE;
          end else begin
            scan_nxt  = '0;
            issue_nxt = 1'b1;
            pv_nxt    = 1'b0;
            state_nxt = S_SCAN2;
          end
        end
      end

      S_SCAN2: begin
        // Drop cancelled entries that order ahead of the winner
        if (pv_r && valid_r[pidx_r] && canc_r[pidx_r] && ahead) begin
          valid_nxt[pidx_r] = 1'b0;
          canc_nxt[pidx_r]  = 1'b0;
          cnt_nxt           = cnt_nxt - CW'(1);
        end
        if (last_proc) begin
          valid_nxt[bidx_r] = 1'b0;
          canc_nxt[bidx_r]  = 1'b0;
          cnt_nxt           = cnt_nxt - CW'(1);
          deq_nxt           = deq_r + 64'd1;
          sts_nxt           = sjfq_pkg::STS_OK;
          gid_nxt           = bid_r;
          gpri_nxt          = bprio_r;
          state_nxt         = S_DONE;
        end
      end

      S_CANCEL: begin
        if (pv_r && valid_r[pidx_r] && rd.id == req_r.job_id) begin
          canc_nxt[pidx_r] = 1'b1;
          found_nxt        = 1'b1;
        end
        if (last_proc) begin
          sts_nxt   = found_nxt ? sjfq_pkg::STS_OK : sjfq_pkg::STS_MISS;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_nxt.status           = sts_r;
          out_nxt.granted_id       = gid_r;
          out_nxt.granted_priority = gpri_r;
          out_nxt.queue_depth      = 5'(cnt_r);
          out_nxt.enqueued_total   = enq_r;
          out_nxt.dequeued_total   = deq_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      canc_r      <= '0;
      cnt_r       <= '0;
      arr_ctr_r   <= '0;
      enq_r       <= '0;
      deq_r       <= '0;
      issue_r     <= 1'b0;
      pv_r        <= 1'b0;
      bfound_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      canc_r      <= canc_nxt;
      cnt_r       <= cnt_nxt;
      arr_ctr_r   <= arr_ctr_nxt;
      enq_r       <= enq_nxt;
      deq_r       <= deq_nxt;
      issue_r     <= issue_nxt;
      pv_r        <= pv_nxt;
      bfound_r    <= bfound_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    scan_r  <= scan_nxt;
    pidx_r  <= pidx_nxt;
    bidx_r  <= bidx_nxt;
    bprio_r <= bprio_nxt;
    bage_r  <= bage_nxt;
    bid_r   <= bid_nxt;
    sts_r   <= sts_nxt;
    gid_r   <= gid_nxt;
    gpri_r  <= gpri_nxt;
    out_r   <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for shortest_job_first_queue: a directed table, then random
// request traffic, each result checked against the table or a behavioral queue model.
// Depends on sjfq_pkg and the RTL under design/.
`timescale 1ns / 100ps

module tb_top;
  import sjfq_pkg::*;

  localparam int QDEPTH = 16;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_REQS = 1500;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int MAX_PRINTS = 100;

  typedef struct {
    req_t req;
    int   rep;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_req;
  logic out_valid;
  logic out_stall;
  rsp_t out_rsp;

  // Behavioral copy of the queue
  bit          q_used [QDEPTH];
  bit          q_cxl  [QDEPTH];
  logic [15:0] q_id   [QDEPTH];
  logic [15:0] q_pri  [QDEPTH];
  logic [31:0] q_arr  [QDEPTH];
  logic [31:0] arrival_stamp;
  logic [63:0] enq_total;
  logic [63:0] deq_total;

  rsp_t      pending_rsp[$];
  plan_row_t plan[$];
  int        n_mismatch;
  int        n_accepted;
  bit        calm;
  bit        hold_done;
  int        hold_left;

  shortest_job_first_queue uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    n_mismatch++;
    if (n_mismatch <= MAX_PRINTS)
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
  endtask

  // True when slot a is served ahead of slot b
  function automatic bit serves_first(int a, int b);
    logic [31:0] age_a;
    logic [31:0] age_b;
    if (q_pri[a] != q_pri[b]) return q_pri[a] < q_pri[b];
    age_a = arrival_stamp - q_arr[a];
    age_b = arrival_stamp - q_arr[b];
    if (age_a != age_b) return age_a > age_b;
    return a < b;
  endfunction

  function automatic rsp_t predict_response(req_t r);
    rsp_t o;
    int   slot;
    int   best;
    int   held;
    bit   found;
    o = '0;
    o.status = STS_MISS;
    if (r.req_type == REQ_ENQ) begin
      slot = -1;
      for (int i = 0; i < QDEPTH; i++)
        if (!q_used[i] && slot < 0) slot = i;
      if (slot < 0) begin
        o.status = STS_FULL;
      end else begin
        q_used[slot] = 1'b1;
        q_cxl[slot] = 1'b0;
        q_id[slot] = r.job_id;
        q_pri[slot] = (r.pred_len != 16'd0) ? r.pred_len : r.len_limit;
        q_arr[slot] = arrival_stamp;
        arrival_stamp++;
        enq_total++;
        o.status = STS_OK;
      end
    end else if (r.req_type == REQ_DEQ) begin
      best = -1;
      for (int i = 0; i < QDEPTH; i++)
        if (q_used[i] && !q_cxl[i] && (best < 0 || serves_first(i, best))) best = i;
      if (best < 0) begin
        // nothing servable: drop every cancelled entry
        for (int i = 0; i < QDEPTH; i++) begin
          q_used[i] = 1'b0;
          q_cxl[i] = 1'b0;
        end
      end else begin
        for (int i = 0; i < QDEPTH; i++)
          if (q_used[i] && q_cxl[i] && serves_first(i, best)) begin
            q_used[i] = 1'b0;
            q_cxl[i] = 1'b0;
          end
        o.granted_id = q_id[best];
        o.granted_priority = q_pri[best];
        q_used[best] = 1'b0;
        q_cxl[best] = 1'b0;
        deq_total++;
        o.status = STS_OK;
      end
    end else if (r.req_type == REQ_CANCEL) begin
      found = 1'b0;
      for (int i = 0; i < QDEPTH; i++)
        if (q_used[i] && q_id[i] == r.job_id) begin
          q_cxl[i] = 1'b1;
          found = 1'b1;
        end
      o.status = found ? STS_OK : STS_MISS;
    end
    held = 0;
    for (int i = 0; i < QDEPTH; i++)
      if (q_used[i]) held++;
    o.queue_depth = held[4:0];
    o.enqueued_total = enq_total;
    o.dequeued_total = deq_total;
    return o;
  endfunction

  function automatic req_t make_req(logic [1:0] kind, logic [15:0] id, logic [15:0] pred,
                                    logic [15:0] maxt);
    req_t r;
    r.req_type = kind;
    r.job_id = id;
    r.pred_len = pred;
    r.len_limit = maxt;
    return r;
  endfunction

  function automatic rsp_t make_rsp(logic [1:0] st, logic [15:0] gid, logic [15:0] gpri,
                                    logic [4:0] depth, logic [63:0] enq, logic [63:0] deq);
    rsp_t o;
    o.status = st;
    o.granted_id = gid;
    o.granted_priority = gpri;
    o.queue_depth = depth;
    o.enqueued_total = enq;
    o.dequeued_total = deq;
    return o;
  endfunction

  task automatic add_row(logic [1:0] kind, logic [15:0] id, logic [15:0] pred,
                         logic [15:0] maxt, int rep, bit typed, rsp_t want);
    plan_row_t row;
    row.req = make_req(kind, id, pred, maxt);
    row.rep = rep;
    row.typed = typed;
    row.want = want;
    plan.insert(plan.size(), row);
  endtask

  function automatic req_t random_request(bit filling);
    req_t        r;
    int unsigned roll;
    int          live[$];
    r.job_id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(31));
    roll = $urandom_range(99);
    if (roll < 25) r.pred_len = '0;
    else if (roll < 70) r.pred_len = 16'($urandom_range(1, 6));
    else r.pred_len = 16'($urandom);
    r.len_limit = $urandom_range(1) ? 16'($urandom_range(6)) : 16'($urandom);
    roll = $urandom_range(99);
    if (roll < (filling ? 55 : 25)) r.req_type = REQ_ENQ;
    else if (roll < (filling ? 75 : 70)) r.req_type = REQ_DEQ;
    else if (roll < 95) r.req_type = REQ_CANCEL;
    else r.req_type = REQ_UNUSED;
    if (r.req_type == REQ_CANCEL && $urandom_range(3) != 0) begin
      for (int i = 0; i < QDEPTH; i++)
        if (q_used[i]) live.insert(live.size(), i);
      if (live.size() > 0) r.job_id = q_id[live[$urandom_range(live.size() - 1)]];
    end
    return r;
  endfunction

  // Offer one request, hold it until taken, then record what it should return
  task automatic send_request(req_t r, bit typed, rsp_t want);
    rsp_t got;
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = predict_response(r);
    pending_rsp.insert(pending_rsp.size(), typed ? want : got);
    n_accepted++;
    @(negedge clk);
  endtask

  // Request side: reset, directed table, random traffic, drain
  initial begin
    req_t r;
    int   n_random;
    bit   filling;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    n_mismatch = 0;
    n_accepted = 0;
    calm = 1'b0;
    arrival_stamp = '0;
    enq_total = '0;
    deq_total = '0;
    for (int i = 0; i < QDEPTH; i++) begin
      q_used[i] = 1'b0;
      q_cxl[i] = 1'b0;
    end

    add_row(REQ_DEQ, 16'h0000, 16'h0000, 16'h0000, 1, 1'b1,
            make_rsp(STS_MISS, 16'h0, 16'h0, 5'd0, 64'd0, 64'd0));
    add_row(REQ_CANCEL, 16'h0005, 16'h0000, 16'h0000, 1, 1'b1,
            make_rsp(STS_MISS, 16'h0, 16'h0, 5'd0, 64'd0, 64'd0));
    add_row(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1'b1,
            make_rsp(STS_MISS, 16'h0, 16'h0, 5'd0, 64'd0, 64'd0));
    add_row(REQ_ENQ, 16'hFFFF, 16'h0000, 16'hFFFF, 1, 1'b1,
            make_rsp(STS_OK, 16'h0, 16'h0, 5'd1, 64'd1, 64'd0));
    add_row(REQ_ENQ, 16'h0000, 16'hFFFF, 16'h0000, 1, 1'b1,
            make_rsp(STS_OK, 16'h0, 16'h0, 5'd2, 64'd2, 64'd0));
    add_row(REQ_ENQ, 16'h0001, 16'h0001, 16'hFFFF, 1, 1'b1,
            make_rsp(STS_OK, 16'h0, 16'h0, 5'd3, 64'd3, 64'd0));
    add_row(REQ_ENQ, 16'h0002, 16'h0000, 16'h0000, 1, 1'b1,
            make_rsp(STS_OK, 16'h0, 16'h0, 5'd4, 64'd4, 64'd0));
    add_row(REQ_DEQ, 16'h0000, 16'h0000, 16'h0000, 1, 1'b1,
            make_rsp(STS_OK, 16'h0002, 16'h0000, 5'd3, 64'd4, 64'd1));
    // cancelled entry ordered ahead of the one served
    add_row(REQ_CANCEL, 16'h0001, 16'h0000, 16'h0000, 1, 1'b0, '0);
    add_row(REQ_DEQ, 16'h0000, 16'h0000, 16'h0000, 1, 1'b0, '0);
    // cancel twice, then only cancelled entries remain
    add_row(REQ_CANCEL, 16'h0000, 16'h0000, 16'h0000, 2, 1'b0, '0);
    add_row(REQ_DEQ, 16'h0000, 16'h0000, 16'h0000, 1, 1'b0, '0);
    // duplicate ids: one cancel marks both
    add_row(REQ_ENQ, 16'h0007, 16'h0005, 16'h0000, 1, 1'b0, '0);
    add_row(REQ_ENQ, 16'h0007, 16'h0005, 16'h0000, 1, 1'b0, '0);
    add_row(REQ_CANCEL, 16'h0007, 16'h0000, 16'h0000, 1, 1'b0, '0);
    add_row(REQ_ENQ, 16'h0009, 16'h0005, 16'h0000, 1, 1'b0, '0);
    add_row(REQ_DEQ, 16'h0000, 16'h0000, 16'h0000, 1, 1'b0, '0);
    // fill, overflow, then drain past empty
    add_row(REQ_ENQ, 16'h0100, 16'h0003, 16'h0000, QDEPTH, 1'b0, '0);
    add_row(REQ_ENQ, 16'hABCD, 16'h0001, 16'h0000, 1, 1'b0, '0);
    add_row(REQ_CANCEL, 16'h0100, 16'h0000, 16'h0000, 1, 1'b0, '0);
    add_row(REQ_DEQ, 16'h0000, 16'h0000, 16'h0000, QDEPTH + 1, 1'b0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[k])
      for (int j = 0; j < plan[k].rep; j++) begin
        r = plan[k].req;
        if (r.req_type == REQ_ENQ) r.job_id = r.job_id + 16'(j);
        send_request(r, plan[k].typed, plan[k].want);
      end

    n_random = 0;
    filling = 1'b1;
    while (n_random < RANDOM_REQS) begin
      if (n_random % 40 == 0) filling = $urandom_range(1);
      calm = (n_random >= 700 && n_random < 1000);
      if (n_random == 1200) begin
        // pause until every outstanding result is back
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      r = random_request(filling);
      send_request(r, 1'b0, '0);
      if (r.req_type != REQ_UNUSED) n_random++;
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side stall: random, plus one long hold-off while requests keep coming
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (!hold_done && n_accepted >= 300) begin
        hold_left = HOLDOFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 21);
      end
    end
  end

  always @(posedge clk) begin : result_check
    rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("result with nothing pending, status", 64'(out_rsp.status), 64'd0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp.status !== want.status)
          report_mismatch("status", 64'(out_rsp.status), 64'(want.status));
        if (out_rsp.granted_id !== want.granted_id)
          report_mismatch("granted_id", 64'(out_rsp.granted_id), 64'(want.granted_id));
        if (out_rsp.granted_priority !== want.granted_priority)
          report_mismatch("granted_priority", 64'(out_rsp.granted_priority),
                          64'(want.granted_priority));
        if (out_rsp.queue_depth !== want.queue_depth)
          report_mismatch("queue_depth", 64'(out_rsp.queue_depth), 64'(want.queue_depth));
        if (out_rsp.enqueued_total !== want.enqueued_total)
          report_mismatch("enqueued_total", out_rsp.enqueued_total, want.enqueued_total);
        if (out_rsp.dequeued_total !== want.dequeued_total)
          report_mismatch("dequeued_total", out_rsp.dequeued_total, want.dequeued_total);
      end
    end
  end

endmodule

// ===== sim.f =====
design/sjfq_pkg.sv
design/sjfq_ram.sv
design/sjfq_cmp.sv
design/shortest_job_first_queue.sv
dv/tb_top.sv
